@@ rtl/lccq_pkg.sv @@
// Shared types and constants for the LED chaser command queue.
`default_nettype none
package lccq_pkg;

  localparam int LED_W    = 10;  // led_pattern width
  localparam int STATUS_W = 2;
  localparam int QCNT_W   = 5;   // queued_count width
  localparam int POS_W    = 5;   // covers up to 32 LEDs
  localparam int DWELL_W  = 16;

  localparam logic [DWELL_W-1:0] INTERVAL_RESET = 16'd1000;

  // Work queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ENQ  = 1'b1;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  localparam logic [1:0] REG_INTERVAL = 2'd0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_QUEUED = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_TICK   = 2'd2
  } status_t;

  // One resolved item on its way to the output
  typedef struct packed {
    status_t           status;
    logic              busy;
    logic [POS_W-1:0]  pos;
    logic [QCNT_W-1:0] count;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/lccq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lccq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire [WIDTH-1:0]          wr_data,
  input  wire                      rd_en,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lccq_front.sv @@
// Front end: config register, command FIFO control, chaser counters.
`default_nettype none
module lccq_front #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LEDS    = 10
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire                         in_op,
  input  wire                         in_dir,
  input  wire                         cfg_wr,
  input  wire [lccq_pkg::DWELL_W-1:0] cfg_wdata,
  output logic [lccq_pkg::DWELL_W-1:0] interval,
  input  wire [lccq_pkg::Q_CNT_W-1:0] q_count,
  output logic                        q_push,
  output lccq_pkg::item_t             q_item
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W = $clog2(NUM_LEDS);

  logic [PTR_W-1:0]  rptr_r, rptr_nxt, wptr_r, wptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              running_r, running_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [lccq_pkg::DWELL_W-1:0] dwell_r, dwell_nxt, dwell_inc, limit;
  logic [lccq_pkg::DWELL_W-1:0] interval_r;
  lccq_pkg::status_t status;

  logic              s1_valid_r;
  lccq_pkg::status_t s1_status_r;
  logic              s1_busy_r;
  logic [STEP_W-1:0] s1_step_r;
  logic [CNT_W-1:0]  s1_count_r;

  logic              accept, wr_en, rd_en, dir_q;
  logic [lccq_pkg::Q_CNT_W:0] occupancy;

  assign occupancy = {1'b0, q_count} + (lccq_pkg::Q_CNT_W + 1)'(s1_valid_r);
  assign in_tready = occupancy < (lccq_pkg::Q_CNT_W + 1)'(lccq_pkg::Q_DEPTH);
  assign accept    = in_tvalid & in_tready;
  assign interval  = interval_r;
  assign limit     = (interval_r == '0) ? lccq_pkg::DWELL_W'(1) : interval_r;
  assign dwell_inc = dwell_r + lccq_pkg::DWELL_W'(1);

  always_comb begin
    rptr_nxt    = rptr_r;
    wptr_nxt    = wptr_r;
    count_nxt   = count_r;
    running_nxt = running_r;
    step_nxt    = step_r;
    dwell_nxt   = dwell_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    status      = lccq_pkg::STATUS_TICK;
    if (accept) begin
      if (in_op == lccq_pkg::OP_ENQ) begin
        if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          status = lccq_pkg::STATUS_FULL;
        end else begin
          status    = lccq_pkg::STATUS_QUEUED;
          wr_en     = 1'b1;
          wptr_nxt  = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (!running_r) begin
        // idle: pop the head command; its direction arrives from the RAM next cycle
        if (count_r != '0) begin
          rd_en       = 1'b1;
          rptr_nxt    = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
          count_nxt   = count_r - CNT_W'(1);
          running_nxt = 1'b1;
          step_nxt    = '0;
          dwell_nxt   = '0;
        end
      end else if (dwell_inc < limit) begin
        dwell_nxt = dwell_inc;
      end else begin
        dwell_nxt = '0;
        if (step_r == STEP_W'(NUM_LEDS - 1)) begin
          running_nxt = 1'b0;
          step_nxt    = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r     <= '0;
      wptr_r     <= '0;
      count_r    <= '0;
      running_r  <= 1'b0;
      step_r     <= '0;
      dwell_r    <= '0;
      interval_r <= lccq_pkg::INTERVAL_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      rptr_r     <= rptr_nxt;
      wptr_r     <= wptr_nxt;
      count_r    <= count_nxt;
      running_r  <= running_nxt;
      step_r     <= step_nxt;
      dwell_r    <= dwell_nxt;
      s1_valid_r <= accept;
      if (cfg_wr) begin
        interval_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= status;
    s1_busy_r   <= running_nxt;
    s1_step_r   <= step_nxt;
    s1_count_r  <= count_nxt;
  end

  // Read data holds the direction of the most recent pop, i.e. the running chase
  lccq_ram #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wptr_r),
    .wr_data (in_dir),
    .rd_en   (rd_en),
    .rd_addr (rptr_r),
    .rd_data (dir_q)
  );

  always_comb begin
    q_push        = s1_valid_r;
    q_item.status = s1_status_r;
    q_item.busy   = s1_busy_r;
    q_item.pos    = (dir_q == lccq_pkg::DIR_DOWN)
                    ? lccq_pkg::POS_W'(NUM_LEDS - 1) - lccq_pkg::POS_W'(s1_step_r)
                    : lccq_pkg::POS_W'(s1_step_r);
    q_item.count  = lccq_pkg::QCNT_W'(s1_count_r);
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("command count above queue depth");
  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted word did not reach the resolve stage");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> step_r <= STEP_W'(NUM_LEDS - 1))
    else $error("chaser step past last LED");
`endif

endmodule
`default_nettype wire

@@ rtl/lccq_queue.sv @@
// Short work queue between the front end and the output stage.
`default_nettype none
module lccq_queue (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  input  lccq_pkg::item_t              push_item,
  input  wire                          pop,
  output logic                         head_valid,
  output lccq_pkg::item_t              head_item,
  output logic [lccq_pkg::Q_CNT_W-1:0] count
);

  lccq_pkg::item_t mem_r [lccq_pkg::Q_DEPTH];
  logic [lccq_pkg::Q_PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [lccq_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = pop  ? head_r + lccq_pkg::Q_PTR_W'(1) : head_r;
    tail_nxt  = push ? tail_r + lccq_pkg::Q_PTR_W'(1) : tail_r;
    count_nxt = count_r + lccq_pkg::Q_CNT_W'(push) - lccq_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_item;
    end
  end

  assign head_valid = count_r != '0;
  assign head_item  = mem_r[head_r];
  assign count      = count_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> count_r < lccq_pkg::Q_CNT_W'(lccq_pkg::Q_DEPTH))
    else $error("work queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("work queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + lccq_pkg::Q_CNT_W'(1))
    else $error("work queue count did not advance on push");
`endif

endmodule
`default_nettype wire

@@ rtl/lccq_back.sv @@
// Back end: decode LED position into a pattern and hold the result word.
`default_nettype none
module lccq_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  input  lccq_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire             out_tready,
  output logic [15:0]     out_tdata,
  output logic [1:0]      out_tuser
);

  logic        valid_r, valid_nxt;
  logic [15:0] data_r;
  logic [1:0]  user_r;
  logic [31:0] onehot;
  logic [lccq_pkg::LED_W-1:0] pattern;

  assign q_pop     = q_valid & (~valid_r | out_tready);
  assign onehot    = 32'd1 << q_item.pos;
  assign pattern   = q_item.busy ? onehot[lccq_pkg::LED_W-1:0] : '0;
  assign valid_nxt = q_pop | (valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= {q_item.count, q_item.busy, pattern};
      user_r <= q_item.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

@@ rtl/led_chaser_command_queue.sv @@
// Top level of the LED chaser with a command queue.
//
//  channel  dir   handshake                 payload
//  in_      in    in_tvalid / in_tready     tuser operation, tdata direction
//  out_     out   out_tvalid / out_tready   tuser status, tdata pattern/busy/count
//  cfg_     in    APB, pready tied high     reg 0 interval_ticks at 0x0
//
// One word per cycle while in_tready is high; an accepted word passes the direction fetch
// from the command RAM, the work queue and the output register before it reaches out_.
// in_tready drops only when the four-entry work queue and the resolve stage together
// hold four words, which happens only while out_tready is held low.
// Synchronous active-low reset; the command RAM is not cleared and needs no sweep.
`default_nettype none
module led_chaser_command_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LEDS    = 10
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [7:0]   in_tdata,   // [0] direction, [7:1] zero
  input  wire [0:0]   in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [9:0] led_pattern, [10] busy_res, [15:11] queued_count
  output logic [1:0]  out_tuser,  // [1:0] status
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire [1:0]   cfg_paddr,
  input  wire [31:0]  cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                          cfg_wr;
  logic [lccq_pkg::DWELL_W-1:0]  interval;
  logic [lccq_pkg::Q_CNT_W-1:0]  q_count;
  logic                          q_push, q_pop, q_valid;
  lccq_pkg::item_t               push_item, head_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr == lccq_pkg::REG_INTERVAL);
  assign cfg_prdata = (cfg_paddr == lccq_pkg::REG_INTERVAL) ? {16'd0, interval} : 32'd0;

  lccq_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_LEDS    (NUM_LEDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[0]),
    .in_dir    (in_tdata[0]),
    .cfg_wr    (cfg_wr),
    .cfg_wdata (cfg_pwdata[lccq_pkg::DWELL_W-1:0]),
    .interval  (interval),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  lccq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  lccq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
